// ----- rtl/core/sctf_pkg.sv -----
// Shared types, scancode constants and the set 1 key table for the scancode translator.
// No dependencies.
package sctf_pkg;

   // item operation codes
   localparam logic [1:0] OP_SCAN = 2'd0;
   localparam logic [1:0] OP_CHAR = 2'd1;
   localparam logic [1:0] OP_CODE = 2'd2;

   localparam logic [7:0] SC_ALT_DN    = 8'h38;
   localparam logic [7:0] SC_ALT_UP    = 8'hB8;
   localparam logic [7:0] SC_LSHIFT_DN = 8'h2A;
   localparam logic [7:0] SC_RSHIFT_DN = 8'h36;
   localparam logic [7:0] SC_LSHIFT_UP = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_UP = 8'hB6;
   localparam logic [7:0] SC_CTRL_DN   = 8'h1D;
   localparam logic [7:0] SC_CTRL_UP   = 8'h9D;
   localparam logic [7:0] SC_TAB       = 8'h0F;
   localparam logic [7:0] SC_RELEASE   = 8'h80;
   localparam logic [7:0] KEYMAP_LEN   = 8'd58;

   localparam int CHAR_W = 7;
   localparam int CODE_W = 8;

   typedef struct packed {
      logic alt;
      logic shift;
      logic ctrl;
   } key_flags_type;

   typedef struct packed {
      logic              alt_tab;
      logic              push_code;
      logic              push_char;
      logic [CHAR_W-1:0] char_val;
   } key_evt_type;

   // set 1 press code to character, zero where the key has no character
   function automatic logic [CHAR_W-1:0] keymap(input logic [5:0] idx);
      logic [CHAR_W-1:0] c;
      case (idx)
         6'd1:    c = 7'd27;   // esc
         6'd2:    c = 7'd49;
         6'd3:    c = 7'd50;
         6'd4:    c = 7'd51;
         6'd5:    c = 7'd52;
         6'd6:    c = 7'd53;
         6'd7:    c = 7'd54;
         6'd8:    c = 7'd55;
         6'd9:    c = 7'd56;
         6'd10:   c = 7'd57;
         6'd11:   c = 7'd48;
         6'd12:   c = 7'd45;   // -
         6'd13:   c = 7'd61;   // =
         6'd14:   c = 7'd8;    // backspace
         6'd15:   c = 7'd9;    // tab
         6'd16:   c = 7'd113;  // q
         6'd17:   c = 7'd119;
         6'd18:   c = 7'd101;
         6'd19:   c = 7'd114;
         6'd20:   c = 7'd116;
         6'd21:   c = 7'd122;  // z (qwertz layout)
         6'd22:   c = 7'd117;
         6'd23:   c = 7'd105;
         6'd24:   c = 7'd111;
         6'd25:   c = 7'd112;
         6'd26:   c = 7'd91;   // [
         6'd27:   c = 7'd93;   // ]
         6'd28:   c = 7'd10;   // enter
         6'd30:   c = 7'd97;   // a
         6'd31:   c = 7'd115;
         6'd32:   c = 7'd100;
         6'd33:   c = 7'd102;
         6'd34:   c = 7'd103;
         6'd35:   c = 7'd104;
         6'd36:   c = 7'd106;
         6'd37:   c = 7'd107;
         6'd38:   c = 7'd108;
         6'd39:   c = 7'd59;   // ;
         6'd40:   c = 7'd39;   // '
         6'd41:   c = 7'd96;   // `
         6'd43:   c = 7'd92;   // backslash
         6'd44:   c = 7'd121;  // y
         6'd45:   c = 7'd120;
         6'd46:   c = 7'd99;
         6'd47:   c = 7'd118;
         6'd48:   c = 7'd98;
         6'd49:   c = 7'd110;
         6'd50:   c = 7'd109;
         6'd51:   c = 7'd44;   // ,
         6'd52:   c = 7'd46;   // .
         6'd53:   c = 7'd47;   // /
         6'd55:   c = 7'd42;   // keypad *
         6'd57:   c = 7'd32;   // space
         default: c = 7'd0;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/core/sctf_decode.sv -----
// Modifier flag tracking and scancode classification for the translator.
// Depends on sctf_pkg.
module sctf_decode import sctf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          scan_en,    // scancode transfer accepted
   input  logic [7:0]    scan_byte,
   output key_evt_type   evt,
   output key_flags_type flags
);

   key_flags_type flags_ff, flags_in;
   logic [CHAR_W-1:0] map_char;

   assign map_char = keymap(scan_byte[5:0]);

   always_comb begin
      flags_in = flags_ff;
      evt      = '0;
      if (scan_en) begin
         case (scan_byte)
            SC_ALT_DN:                  flags_in.alt   = 1'b1;
            SC_ALT_UP:                  flags_in.alt   = 1'b0;
            SC_LSHIFT_DN, SC_RSHIFT_DN: flags_in.shift = 1'b1;
            SC_LSHIFT_UP, SC_RSHIFT_UP: flags_in.shift = 1'b0;
            SC_CTRL_DN:                 flags_in.ctrl  = 1'b1;
            SC_CTRL_UP:                 flags_in.ctrl  = 1'b0;
            default:                    ;
         endcase
         if (scan_byte == SC_TAB && flags_ff.alt) begin
            // task switch: swallowed, not buffered
            flags_in.alt = 1'b0;
            evt.alt_tab  = 1'b1;
         end else begin
            evt.push_code = 1'b1;
            // below the table length implies bit 7 clear, i.e. a press code
            evt.push_char = (scan_byte < KEYMAP_LEN) && (map_char != '0);
            evt.char_val  = map_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   assign flags = flags_ff;

endmodule

// ----- rtl/core/sctf_fifo.sv -----
// Circular buffer with registered read port; holds at most DEPTH-1 entries.
// Depends on sctf_pkg.
module sctf_fifo import sctf_pkg::*; #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_nxt, rd_nxt;
   logic [WIDTH-1:0] rdata_ff;
   logic             full, do_push, do_pop;

   assign wr_nxt  = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_nxt  = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
   assign empty   = (wr_ptr_ff == rd_ptr_ff);
   assign full    = (wr_nxt == rd_ptr_ff);
   assign do_push = push && !full;    // full drops silently
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_nxt : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_nxt : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         rdata_ff <= mem[rd_ptr_ff];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/scancode_translator_fifo_core.sv -----
// Top level of the set 1 scancode translator with ASCII and raw scancode queues.
// Depends on sctf_pkg, sctf_decode and sctf_fifo.
//
// Takes one request per clock unless rsp_tready stalls it, and returns exactly one
// response per request, in order. Each request passes through two stages, the registered
// read port of the queue memories and the output register; rsp_tvalid rises once it
// reaches the output register. With rsp_tready held high the block sustains one
// transfer per cycle.
// op 0 delivers a scancode: modifier flags follow their press and release codes, tab with
// alt held reports alt_tab and clears alt, every other code is queued raw and press codes
// with a character are also queued as ASCII. op 1 pops a character (ascii_empty when
// none), op 2 pops a raw code (zero when none), op 3 only reports the flags. A full queue
// drops the new entry; each queue holds at most depth minus one entries.
module scancode_translator_fifo_core import sctf_pkg::*; #(
   parameter int CHAR_DEPTH = 256,
   parameter int CODE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] op, [9:2] scan_byte, [15:10] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [0] alt_tab, [7:1] ascii_char, [8] ascii_empty,
                                    // [16:9] raw_code, [17] alt_down, [18] shift_down,
                                    // [19] ctrl_down, [23:20] zero
);

   logic [1:0]        op;
   logic [7:0]        scan_byte;
   logic              req_xfer, a_adv;
   key_evt_type       evt;
   key_flags_type     flags;
   logic              char_empty, code_empty, char_pop, code_pop;
   logic [CHAR_W-1:0] char_rdata;
   logic [CODE_W-1:0] code_rdata;

   // stage A: after queue access
   logic a_valid_ff, a_alt_tab_ff, a_char_op_ff, a_char_hit_ff, a_code_hit_ff;
   // stage B: response register
   logic              b_valid_ff;
   logic              b_alt_tab_ff, b_empty_ff;
   logic [CHAR_W-1:0] b_char_ff;
   logic [CODE_W-1:0] b_code_ff;
   key_flags_type     b_flags_ff;

   assign op        = req_tdata[1:0];
   assign scan_byte = req_tdata[9:2];

   assign a_adv      = a_valid_ff && (!b_valid_ff || rsp_tready);
   assign req_tready = !a_valid_ff || a_adv;
   assign req_xfer   = req_tvalid && req_tready;
   assign char_pop   = req_xfer && (op == OP_CHAR);
   assign code_pop   = req_xfer && (op == OP_CODE);

   sctf_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .scan_en   (req_xfer && (op == OP_SCAN)),
      .scan_byte (scan_byte),
      .evt       (evt),
      .flags     (flags)
   );

   sctf_fifo #(.DEPTH(CHAR_DEPTH), .WIDTH(CHAR_W)) u_char_fifo (
      .clock (clock),
      .reset (reset),
      .push  (evt.push_char),
      .wdata (evt.char_val),
      .pop   (char_pop),
      .empty (char_empty),
      .rdata (char_rdata)
   );

   sctf_fifo #(.DEPTH(CODE_DEPTH), .WIDTH(CODE_W)) u_code_fifo (
      .clock (clock),
      .reset (reset),
      .push  (evt.push_code),
      .wdata (scan_byte),
      .pop   (code_pop),
      .empty (code_empty),
      .rdata (code_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_tready) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         a_alt_tab_ff  <= evt.alt_tab;
         a_char_op_ff  <= char_pop;
         a_char_hit_ff <= char_pop && !char_empty;
         a_code_hit_ff <= code_pop && !code_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (!b_valid_ff || rsp_tready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   // flag registers and queue read data still belong to the stage A item here
   always_ff @(posedge clock) begin
      if (a_adv) begin
         b_alt_tab_ff <= a_alt_tab_ff;
         b_empty_ff   <= a_char_op_ff && !a_char_hit_ff;
         b_char_ff    <= a_char_hit_ff ? char_rdata : '0;
         b_code_ff    <= a_code_hit_ff ? code_rdata : '0;
         b_flags_ff   <= flags;
      end
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = {4'b0, b_flags_ff.ctrl, b_flags_ff.shift, b_flags_ff.alt,
                        b_code_ff, b_empty_ff, b_char_ff, b_alt_tab_ff};

   a_alt_tab_no_pop: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && a_alt_tab_ff |-> !a_char_hit_ff && !a_code_hit_ff)
      else $error("alt_tab item also popped a queue");

   a_tab_clears_alt: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (op == OP_SCAN) && (scan_byte == SC_TAB) && flags.alt |=> !flags.alt)
      else $error("alt+tab did not clear alt");

   a_empty_no_char: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_empty_ff |-> (b_char_ff == '0) && !b_alt_tab_ff)
      else $error("empty response carries a character");

   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      a_adv |=> b_valid_ff)
      else $error("stage A item lost on advance");

endmodule
